// ===== hdl/mhi_pkg.sv =====
package mhi_pkg;

    localparam int CAPACITY = 128;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;
    // one sift level per cycle, plus a last step for the token to retire at a leaf
    localparam int SIFT_CYC = IDX_W + 1;
    localparam int SC_W     = $clog2(SIFT_CYC);

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    typedef enum logic [1:0] {
        STAT_DONE     = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_NOTFOUND = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CMD_IDLE,
        CMD_INSERT,
        CMD_APPLY,
        CMD_SIFT
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INSERT,
        ST_LAUNCH,
        ST_SEARCH,
        ST_APPLY,
        ST_SIFT,
        ST_DONE
    } t_state;

    // command broadcast from the controller to every cell
    typedef struct packed {
        t_cmd                     cmd;
        logic [CNT_W-1:0]         count;
        logic signed [VAL_W-1:0]  data;
    } t_bcast;

    // scan beat handed from one cell to the next
    typedef struct packed {
        logic                     tok;
        logic                     fnd;
        logic signed [VAL_W-1:0]  carry;
    } t_scan;

    // what a cell shows its two children
    typedef struct packed {
        logic signed [VAL_W-1:0]  val;
        logic                     swap_l;
        logic                     swap_r;
    } t_par_link;

    // what a cell shows its parent
    typedef struct packed {
        logic signed [VAL_W-1:0]  val;
        logic                     swap_up;
    } t_kid_link;

    localparam t_scan     SCAN_TIE = '0;
    localparam t_par_link PAR_TIE  = '0;
    localparam t_kid_link KID_TIE  = '0;

endpackage

// ===== hdl/max_heap_insert_delete_core.sv =====
// Channel  | Ports                                          | Handshake
// ---------+------------------------------------------------+-------------------------------
// command  | i_operation, i_value                           | taken when start && !busy
// result   | o_status, o_entry_count, o_top_value, o_is_empty | o_valid, one cycle, no stall
//
// Insert: after accept, a load step, the sift steps and a result step that raises the strobe;
// an insert into a full heap goes straight to the result step.
// Delete: the scan beat walks all CAPACITY cells one per cycle; on a hit the last entry
// moves into the freed slot and sifts one tree level per cycle before the result step.
// busy stays high from accept through the strobe cycle; one command is in flight at a time.
// Reset (synchronous, active low) empties the heap; cell values are undefined until written.
module max_heap_insert_delete_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             i_operation,
    input  logic signed [mhi_pkg::VAL_W-1:0] i_value,
    output logic                             o_valid,
    output logic [1:0]                       o_status,
    output logic [mhi_pkg::CNT_W-1:0]        o_entry_count,
    output logic signed [mhi_pkg::VAL_W-1:0] o_top_value,
    output logic                             o_is_empty
);
    import mhi_pkg::*;

    t_bcast    bc;
    t_scan     scan_head;
    t_scan     scan_out [CAPACITY];
    t_par_link dn       [CAPACITY];
    t_kid_link up       [CAPACITY];

    mhi_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_operation   (i_operation),
        .i_value       (i_value),
        .i_scan_end    (scan_out[CAPACITY-1]),
        .i_root_val    (dn[0].val),
        .o_bc          (bc),
        .o_scan_head   (scan_head),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_entry_count (o_entry_count),
        .o_top_value   (o_top_value),
        .o_is_empty    (o_is_empty)
    );

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_scan     scan_in;
        t_par_link par_in;
        t_kid_link kid_l_in, kid_r_in;

        if (g == 0) begin : g_head
            assign scan_in = scan_head;
            assign par_in  = PAR_TIE;
        end else begin : g_body
            assign scan_in = scan_out[g-1];
            assign par_in  = dn[(g-1)/2];
        end

        if (2*g + 1 < CAPACITY) begin : g_has_l
            assign kid_l_in = up[2*g+1];
        end else begin : g_no_l
            assign kid_l_in = KID_TIE;
        end

        if (2*g + 2 < CAPACITY) begin : g_has_r
            assign kid_r_in = up[2*g+2];
        end else begin : g_no_r
            assign kid_r_in = KID_TIE;
        end

        mhi_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (IDX_W'(g)),
            .i_bc    (bc),
            .i_scan  (scan_in),
            .o_scan  (scan_out[g]),
            .i_par   (par_in),
            .i_kid_l (kid_l_in),
            .i_kid_r (kid_r_in),
            .o_dn    (dn[g]),
            .o_up    (up[g])
        );
    end

endmodule

// ===== hdl/mhi_cell.sv =====
module mhi_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [mhi_pkg::IDX_W-1:0] i_index,
    input  mhi_pkg::t_bcast           i_bc,
    input  mhi_pkg::t_scan            i_scan,
    output mhi_pkg::t_scan            o_scan,
    input  mhi_pkg::t_par_link        i_par,
    input  mhi_pkg::t_kid_link        i_kid_l,
    input  mhi_pkg::t_kid_link        i_kid_r,
    output mhi_pkg::t_par_link        o_dn,
    output mhi_pkg::t_kid_link        o_up
);
    import mhi_pkg::*;

    logic signed [VAL_W-1:0] r_val, n_val;
    logic                    r_act, n_act;
    logic                    r_dir_up, n_dir_up;
    logic                    r_hit, n_hit;
    logic                    r_tok;
    logic                    r_fnd;
    logic signed [VAL_W-1:0] r_carry;

    logic [CNT_W-1:0]  k_cnt;
    logic [IDX_W+1:0]  l_idx, r_idx, cnt_ext;
    logic              l_ok, r_ok, in_use, has_par, is_left, sifting, hit_now;
    logic              up_go, go_l, go_r;

    assign k_cnt   = CNT_W'(i_index);
    assign l_idx   = {1'b0, i_index, 1'b1};
    assign r_idx   = l_idx + (IDX_W+2)'(1);
    assign cnt_ext = (IDX_W+2)'(i_bc.count);
    assign l_ok    = l_idx < cnt_ext;
    assign r_ok    = r_idx < cnt_ext;
    assign in_use  = k_cnt < i_bc.count;
    assign has_par = i_index != '0;
    assign is_left = i_index[0];
    assign sifting = i_bc.cmd == CMD_SIFT;

    // first match along the scan: only the cell holding the beat can hit
    assign hit_now = r_tok && !r_fnd && in_use && (r_val == i_bc.data);

    always_comb begin
        up_go = 1'b0;
        go_l  = 1'b0;
        go_r  = 1'b0;
        if (sifting && r_act) begin
            if (r_dir_up) begin
                up_go = has_par && (r_val > i_par.val);
            end else if (r_ok) begin
                if (!(r_val >= i_kid_l.val && r_val >= i_kid_r.val)) begin
                    if (i_kid_r.val <= i_kid_l.val) begin
                        go_l = 1'b1;
                    end else begin
                        go_r = 1'b1;
                    end
                end
            end else if (l_ok) begin
                go_l = i_kid_l.val > r_val;
            end
        end
    end

    assign o_up.val     = r_val;
    assign o_up.swap_up = up_go;
    assign o_dn.val     = r_val;
    assign o_dn.swap_l  = go_l;
    assign o_dn.swap_r  = go_r;

    assign o_scan.tok   = r_tok;
    assign o_scan.fnd   = r_fnd | hit_now;
    assign o_scan.carry = in_use ? r_val : r_carry;

    always_comb begin
        n_val    = r_val;
        n_act    = r_act;
        n_dir_up = r_dir_up;
        n_hit    = r_hit | hit_now;
        case (i_bc.cmd)
            CMD_INSERT: begin
                if (k_cnt == i_bc.count) begin
                    n_val    = i_bc.data;
                    n_act    = 1'b1;
                    n_dir_up = 1'b1;
                end
            end
            CMD_APPLY: begin
                n_hit = 1'b0;
                // move the last entry in, unless this slot was the last one
                if (r_hit && k_cnt != i_bc.count) begin
                    n_val    = i_bc.data;
                    n_act    = 1'b1;
                    n_dir_up = has_par && (i_bc.data > i_par.val);
                end
            end
            CMD_SIFT: begin
                if (r_act) begin
                    n_act = 1'b0;
                    if (up_go) begin
                        n_val = i_par.val;
                    end else if (go_l) begin
                        n_val = i_kid_l.val;
                    end else if (go_r) begin
                        n_val = i_kid_r.val;
                    end
                end
                if (i_kid_l.swap_up) begin
                    n_val    = i_kid_l.val;
                    n_act    = 1'b1;
                    n_dir_up = 1'b1;
                end
                if (i_kid_r.swap_up) begin
                    n_val    = i_kid_r.val;
                    n_act    = 1'b1;
                    n_dir_up = 1'b1;
                end
                if (has_par && ((is_left && i_par.swap_l) || (!is_left && i_par.swap_r))) begin
                    n_val    = i_par.val;
                    n_act    = 1'b1;
                    n_dir_up = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
            r_hit <= 1'b0;
            r_tok <= 1'b0;
        end else begin
            r_act <= n_act;
            r_hit <= n_hit;
            r_tok <= i_scan.tok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val    <= n_val;
        r_dir_up <= n_dir_up;
        r_fnd    <= i_scan.fnd;
        r_carry  <= i_scan.carry;
    end

endmodule

// ===== hdl/mhi_ctrl.sv =====
module mhi_ctrl (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             i_operation,
    input  logic signed [mhi_pkg::VAL_W-1:0] i_value,
    input  mhi_pkg::t_scan                   i_scan_end,
    input  logic signed [mhi_pkg::VAL_W-1:0] i_root_val,
    output mhi_pkg::t_bcast                  o_bc,
    output mhi_pkg::t_scan                   o_scan_head,
    output logic                             o_valid,
    output logic [1:0]                       o_status,
    output logic [mhi_pkg::CNT_W-1:0]        o_entry_count,
    output logic signed [mhi_pkg::VAL_W-1:0] o_top_value,
    output logic                             o_is_empty
);
    import mhi_pkg::*;

    t_state                  r_state, n_state;
    logic [CNT_W-1:0]        r_count;
    logic signed [VAL_W-1:0] r_value;
    logic signed [VAL_W-1:0] r_last;
    t_status                 r_status;
    logic [SC_W-1:0]         r_sift_cnt;

    logic accept, full;

    assign accept = start && !busy;
    assign full   = r_count == CNT_W'(CAPACITY);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    if (i_operation == OP_DELETE) begin
                        n_state = ST_LAUNCH;
                    end else if (full) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_INSERT;
                    end
                end
            end
            ST_INSERT: n_state = ST_SIFT;
            ST_LAUNCH: n_state = ST_SEARCH;
            ST_SEARCH: begin
                if (i_scan_end.tok) begin
                    n_state = i_scan_end.fnd ? ST_APPLY : ST_DONE;
                end
            end
            ST_APPLY:  n_state = ST_SIFT;
            ST_SIFT: begin
                if (r_sift_cnt == '0) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE:   n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        busy        = 1'b1;
        o_valid     = 1'b0;
        o_bc.cmd    = CMD_IDLE;
        o_bc.count  = r_count;
        o_bc.data   = r_value;
        o_scan_head = SCAN_TIE;
        case (r_state)
            ST_IDLE:   busy = 1'b0;
            ST_INSERT: o_bc.cmd = CMD_INSERT;
            ST_LAUNCH: o_scan_head.tok = 1'b1;
            ST_APPLY: begin
                o_bc.cmd  = CMD_APPLY;
                o_bc.data = r_last;
            end
            ST_SIFT:   o_bc.cmd = CMD_SIFT;
            ST_DONE:   o_valid = 1'b1;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_INSERT) begin
                r_count <= r_count + CNT_W'(1);
            end else if (r_state == ST_SEARCH && i_scan_end.tok && i_scan_end.fnd) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_value  <= i_value;
            r_status <= (i_operation == OP_INSERT && full) ? STAT_FULL : STAT_DONE;
        end
        if (r_state == ST_SEARCH && i_scan_end.tok) begin
            r_last <= i_scan_end.carry;
            if (!i_scan_end.fnd) begin
                r_status <= STAT_NOTFOUND;
            end
        end
        if (n_state == ST_SIFT && r_state != ST_SIFT) begin
            r_sift_cnt <= SC_W'(SIFT_CYC - 1);
        end else if (r_state == ST_SIFT) begin
            r_sift_cnt <= r_sift_cnt - SC_W'(1);
        end
    end

    assign o_status      = r_status;
    assign o_entry_count = r_count;
    assign o_top_value   = (r_count != '0) ? i_root_val : '0;
    assign o_is_empty    = r_count == '0;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_scan_in_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_scan_end.tok |-> r_state == ST_SEARCH)
        else $error("scan beat left the chain outside a search");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid && !busy)
        else $error("result strobe longer than one cycle");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == STAT_FULL) |-> o_entry_count == CNT_W'(CAPACITY))
        else $error("full status with room left");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("accepted beat did not raise busy");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import mhi_pkg::*;

    localparam int N_RANDOM    = 1880;
    localparam int DRAIN_CYC   = 160;
    localparam int CYCLE_LIMIT = 2_000_000;

    typedef struct {
        t_status                 status;
        logic [CNT_W-1:0]        count;
        logic signed [VAL_W-1:0] top;
        logic                    empty;
    } t_heap_result;

    class t_heap_scoreboard;
        logic signed [VAL_W-1:0] slots [CAPACITY];
        int unsigned             held;
        t_heap_result            awaited_results [$];
        int                      errors;
        int                      checked;
        int                      n_insert;
        int                      n_delete;
        int                      n_full;
        int                      n_absent;

        function new();
            held = 0;
            errors = 0;
            checked = 0;
            n_insert = 0;
            n_delete = 0;
            n_full = 0;
            n_absent = 0;
        endfunction

        function void swap_slots(int unsigned a, int unsigned b);
            logic signed [VAL_W-1:0] tmp;
            tmp = slots[a];
            slots[a] = slots[b];
            slots[b] = tmp;
        endfunction

        function void sift_up(int unsigned pos, logic signed [VAL_W-1:0] v);
            int unsigned up;
            while (pos > 0) begin
                up = (pos - 1) / 2;
                if (v <= slots[up])
                    break;
                slots[pos] = slots[up];
                pos = up;
            end
            slots[pos] = v;
        endfunction

        function void sift_down(int unsigned pos);
            int unsigned l;
            int unsigned r;
            l = 2 * pos + 1;
            r = 2 * pos + 2;
            while (r < held) begin
                if (slots[pos] >= slots[l] && slots[pos] >= slots[r])
                    return;
                // ties go to the left child
                if (slots[r] <= slots[l]) begin
                    swap_slots(pos, l);
                    pos = l;
                end else begin
                    swap_slots(pos, r);
                    pos = r;
                end
                l = 2 * pos + 1;
                r = 2 * pos + 2;
            end
            // lone child moves up only when strictly larger
            if (l < held && slots[l] > slots[pos])
                swap_slots(pos, l);
        endfunction

        function void note_command(logic op, logic signed [VAL_W-1:0] v);
            t_heap_result res;
            int unsigned  idx;
            int unsigned  par;
            bit           found;
            res.status = STAT_DONE;
            if (op == OP_INSERT) begin
                n_insert++;
                if (held >= CAPACITY) begin
                    res.status = STAT_FULL;
                    n_full++;
                end else begin
                    sift_up(held, v);
                    held++;
                end
            end else begin
                n_delete++;
                found = 1'b0;
                for (idx = 0; idx < held; idx++) begin
                    if (slots[idx] == v) begin
                        found = 1'b1;
                        break;
                    end
                end
                if (!found) begin
                    res.status = STAT_NOTFOUND;
                    n_absent++;
                end else begin
                    held--;
                    slots[idx] = slots[held];
                    if (idx < held) begin
                        par = (idx == 0) ? 0 : (idx - 1) / 2;
                        if (idx > 0 && slots[idx] > slots[par])
                            sift_up(idx, slots[idx]);
                        else
                            sift_down(idx);
                    end
                end
            end
            res.count = held[CNT_W-1:0];
            res.top   = (held > 0) ? slots[0] : '0;
            res.empty = (held == 0);
            awaited_results.push_back(res);
        endfunction

        task report_mismatch(string what);
            $display("MISMATCH @%0t: %s", $time, what);
            errors++;
        endtask

        task check_result(logic [1:0] st, logic [CNT_W-1:0] cnt,
                          logic signed [VAL_W-1:0] top, logic empty);
            t_heap_result want;
            checked++;
            if (awaited_results.size() == 0) begin
                report_mismatch("result beat with nothing outstanding");
                return;
            end
            want = awaited_results.pop_front();
            if (st !== want.status)
                report_mismatch($sformatf("status got %0d want %0d", st, want.status));
            if (cnt !== want.count)
                report_mismatch($sformatf("entry_count got %0d want %0d", cnt, want.count));
            if (top !== want.top)
                report_mismatch($sformatf("top_value got %0d want %0d", top, want.top));
            if (empty !== want.empty)
                report_mismatch($sformatf("is_empty got %0b want %0b", empty, want.empty));
        endtask

        function int pending();
            return awaited_results.size();
        endfunction
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    start;
    logic                    busy;
    logic                    i_operation;
    logic signed [VAL_W-1:0] i_value;
    logic                    o_valid;
    logic [1:0]              o_status;
    logic [CNT_W-1:0]        o_entry_count;
    logic signed [VAL_W-1:0] o_top_value;
    logic                    o_is_empty;

    t_heap_scoreboard sb;
    int               idle_pct;
    int               cycle_cnt;

    max_heap_insert_delete_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_operation   (i_operation),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_entry_count (o_entry_count),
        .o_top_value   (o_top_value),
        .o_is_empty    (o_is_empty)
    );

    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            sb.check_result(o_status, o_entry_count, o_top_value, o_is_empty);
    end

    // hold start until the beat is taken; leave start high on return
    task issue(logic op, logic signed [VAL_W-1:0] v);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start       <= 1'b1;
        i_operation <= op;
        i_value     <= v;
        do
            @(posedge i_clk);
        while (busy);
        sb.note_command(op, v);
    endtask

    function automatic logic signed [VAL_W-1:0] pick_value();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 30)
            return $urandom_range(16) - 8;
        if (sel < 40) begin
            case ($urandom_range(4))
                0: return 32'sh7fff_ffff;
                1: return 32'sh8000_0000;
                2: return '0;
                3: return '1;
                default: return 1;
            endcase
        end
        return $urandom();
    endfunction

    initial begin
        int                      n_sent;
        int                      seg;
        int                      seg_len;
        int                      ins_pct;
        int                      k;
        logic signed [VAL_W-1:0] v;

        sb          = new();
        start       = 1'b0;
        i_operation = OP_INSERT;
        i_value     = '0;
        i_rst_n     = 1'b0;
        idle_pct    = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty heap, extremes, last-slot and root removal
        issue(OP_DELETE, 32'sd0);
        issue(OP_INSERT, 32'sh7fff_ffff);
        issue(OP_INSERT, 32'sh8000_0000);
        issue(OP_INSERT, 32'sd0);
        issue(OP_INSERT, -32'sd1);
        issue(OP_DELETE, 32'sh1234_5678);
        issue(OP_DELETE, 32'sh8000_0000);
        issue(OP_DELETE, 32'sh7fff_ffff);
        issue(OP_DELETE, -32'sd1);
        issue(OP_DELETE, 32'sd0);
        // equal children under the moved entry
        issue(OP_INSERT, 32'sd10);
        issue(OP_INSERT, 32'sd7);
        issue(OP_INSERT, 32'sd7);
        issue(OP_INSERT, 32'sd1);
        issue(OP_DELETE, 32'sd10);
        issue(OP_DELETE, 32'sd7);
        issue(OP_DELETE, 32'sd7);
        issue(OP_DELETE, 32'sd1);
        // lone larger child at the end of the sift down
        issue(OP_INSERT, 32'sd9);
        issue(OP_INSERT, 32'sd5);
        issue(OP_INSERT, 32'sd8);
        issue(OP_INSERT, 32'sd3);
        issue(OP_INSERT, 32'sd1);
        issue(OP_DELETE, 32'sd5);

        // grow, mix and shrink segments crossed with three sender idle rates
        n_sent = 0;
        seg = 0;
        while (n_sent < N_RANDOM) begin
            case ((seg / 3) % 3)
                0: idle_pct = 0;
                1: idle_pct = 86;
                default: idle_pct = 24;
            endcase
            case (seg % 3)
                0: ins_pct = 90;
                1: ins_pct = 50;
                default: ins_pct = 10;
            endcase
            seg_len = $urandom_range(120, 230);
            for (k = 0; k < seg_len && n_sent < N_RANDOM; k++) begin
                if ($urandom_range(99) < ins_pct) begin
                    issue(OP_INSERT, pick_value());
                end else begin
                    if (sb.held > 0 && $urandom_range(99) < 75)
                        v = sb.slots[$urandom_range(sb.held - 1)];
                    else
                        v = pick_value();
                    issue(OP_DELETE, v);
                end
                n_sent++;
            end
            seg++;
        end
        start <= 1'b0;

        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);

        $display("Covered %0d inserts (%0d into a full heap), %0d deletes (%0d misses)",
                 sb.n_insert, sb.n_full, sb.n_delete, sb.n_absent);
        $display("Checked %0d result beats, %0d mismatches", sb.checked, sb.errors);
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("Timeout after %0d cycles", cycle_cnt);
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== max_heap_insert_delete_core.f =====
hdl/mhi_pkg.sv
hdl/mhi_cell.sv
hdl/mhi_ctrl.sv
hdl/max_heap_insert_delete_core.sv
tb/tb.sv
